// ===== rtl/command_packet_decoder_crc16_unit_defines.svh =====
// Assertion macros shared by the RTL. Each macro expands to a labeled
// concurrent assertion in simulation and to nothing in synthesis.
`ifndef COMMAND_PACKET_DECODER_CRC16_UNIT_DEFINES_SVH
`define COMMAND_PACKET_DECODER_CRC16_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of aclk once reset has been released.
`define CPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every rising edge of aclk, reset included.
`define CPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CPD_ASSERT(label, prop, msg)
`define CPD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/cpd_pkg.sv =====
package cpd_pkg;

    // Packet layout.
    localparam int unsigned PktLen       = 15;
    localparam int unsigned CrcSpan      = 13;
    localparam int unsigned PayloadFirst = 2;
    localparam int unsigned PayloadDepth = 11;
    localparam int unsigned PosW         = 4;
    localparam int unsigned PayIdxW      = 4;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'h1021;

    // Configuration port.
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 8;
    localparam logic [CfgIdxW-1:0] RegExpectedMagic   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegExpectedVersion = 2'd1;

    // Result beat width: 90 bits of fields padded to whole bytes.
    localparam int unsigned OutDataW = 96;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_BAD_HDR   = 2'd2,
        ST_CRC_BAD   = 2'd3
    } status_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/command_packet_decoder_crc16_unit.sv =====
// Channel | Dir | Beat contents
// --------+-----+-------------------------------------------------------------
// s_      | in  | one packet byte per beat; tlast flags the final byte
// m_      | out | one decoded result per flagged input beat
// cfg_    | in  | register writes: 0 expected magic, 1 expected version
//
// The block takes one byte in every cycle while s_tready is high; the CRC is
// updated a whole byte at a time, and a flagged beat shows its result on the
// next cycle from the output register.
// Reset is synchronous and active low. It clears the byte counter, the header
// flag, the output valid and both configuration registers, and sets the CRC
// to its initial value. The input stalls only when a result sits in the output
// register and the downstream side is not taking it in the same cycle.
`include "command_packet_decoder_crc16_unit_defines.svh"

module command_packet_decoder_crc16_unit (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last_byte

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] status, [9:2] flags, [25:10] sequence_res, [57:26] timestamp_ms,
    // [65:58] pitch, [73:66] roll, [81:74] throttle, [89:82] yaw, rest zero
    output logic [cpd_pkg::OutDataW-1:0]       m_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpd_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [cpd_pkg::CfgDataW-1:0]       cfg_data
);

    localparam logic [cpd_pkg::PosW-1:0] PosLast    = cpd_pkg::PosW'(cpd_pkg::PktLen);
    localparam logic [cpd_pkg::PosW-1:0] PosCrcLo   = cpd_pkg::PosW'(cpd_pkg::CrcSpan);
    localparam logic [cpd_pkg::PosW-1:0] PosCrcHi   = cpd_pkg::PosW'(cpd_pkg::CrcSpan + 1);
    localparam logic [cpd_pkg::PosW-1:0] PosPayload = cpd_pkg::PosW'(cpd_pkg::PayloadFirst);
    localparam logic [cpd_pkg::PosW-1:0] PosMagic   = '0;
    localparam logic [cpd_pkg::PosW-1:0] PosVersion = cpd_pkg::PosW'(1);

    // Configuration registers.
    logic [7:0] magic_reg, magic_next;
    logic [7:0] version_reg, version_next;

    // Per-packet state.
    logic [cpd_pkg::PosW-1:0] pos_reg, pos_next;
    logic [15:0]              crc_reg, crc_next;
    logic                     hdr_bad_reg, hdr_bad_next;
    logic [7:0]               rx_lo_reg, rx_lo_next;
    logic [7:0]               rx_hi_reg, rx_hi_next;
    logic [7:0]               payload_reg [cpd_pkg::PayloadDepth];

    // Output register.
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [cpd_pkg::OutDataW-1:0]  m_tdata_reg, m_tdata_next;

    logic                          s_accept;
    logic                          cfg_accept;
    logic                          pay_we;
    logic [cpd_pkg::PayIdxW-1:0]   pay_idx;
    cpd_pkg::status_t              status;

    // A result may enter the output register whenever it is empty or being
    // drained this cycle, so bytes keep flowing during back-to-back packets.
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Payload bytes 2..12 land in slots 0..10.
    assign pay_idx = cpd_pkg::PayIdxW'(pos_reg - PosPayload);
    assign pay_we  = s_accept && (pos_reg >= PosPayload) && (pos_reg < PosCrcLo);

    always_comb begin
        magic_next   = magic_reg;
        version_next = version_reg;
        if (cfg_accept) begin
            unique case (cfg_index)
                cpd_pkg::RegExpectedMagic:   magic_next   = cfg_data;
                cpd_pkg::RegExpectedVersion: version_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        hdr_bad_next  = hdr_bad_reg;
        rx_lo_next    = rx_lo_reg;
        rx_hi_next    = rx_hi_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        status        = cpd_pkg::ST_OK;

        // Bytes past the fifteenth leave the packet state untouched and the
        // counter stays saturated.
        if (pos_reg < PosLast) begin
            if (pos_reg == PosMagic && s_tdata != magic_reg) begin
                hdr_bad_next = 1'b1;
            end
            if (pos_reg == PosVersion && s_tdata != version_reg) begin
                hdr_bad_next = 1'b1;
            end
            if (pos_reg < PosCrcLo) begin
                crc_next = cpd_pkg::crc_byte(crc_reg, s_tdata);
            end
            if (pos_reg == PosCrcLo) begin
                rx_lo_next = s_tdata;
            end
            if (pos_reg == PosCrcHi) begin
                rx_hi_next = s_tdata;
            end
            pos_next = pos_reg + 1'b1;
        end

        // Checks in priority order: length, header, CRC.
        if (pos_next < PosLast) begin
            status = cpd_pkg::ST_TOO_SHORT;
        end else if (hdr_bad_next) begin
            status = cpd_pkg::ST_BAD_HDR;
        end else if ({rx_hi_next, rx_lo_next} != crc_next) begin
            status = cpd_pkg::ST_CRC_BAD;
        end

        if (!s_accept) begin
            pos_next     = pos_reg;
            crc_next     = crc_reg;
            hdr_bad_next = hdr_bad_reg;
            rx_lo_next   = rx_lo_reg;
            rx_hi_next   = rx_hi_reg;
        end else if (s_tlast) begin
            // An ok packet has all payload bytes stored by earlier beats.
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[1:0] = status;
            if (status == cpd_pkg::ST_OK) begin
                m_tdata_next[9:2]   = payload_reg[0];
                m_tdata_next[25:10] = {payload_reg[2], payload_reg[1]};
                m_tdata_next[57:26] = {payload_reg[6], payload_reg[5],
                                       payload_reg[4], payload_reg[3]};
                m_tdata_next[65:58] = payload_reg[7];
                m_tdata_next[73:66] = payload_reg[8];
                m_tdata_next[81:74] = payload_reg[9];
                m_tdata_next[89:82] = payload_reg[10];
            end
            // Rearm for the next packet.
            pos_next     = '0;
            crc_next     = cpd_pkg::CrcInit;
            hdr_bad_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg    <= '0;
            version_reg  <= '0;
            pos_reg      <= '0;
            crc_reg      <= cpd_pkg::CrcInit;
            hdr_bad_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            magic_reg    <= magic_next;
            version_reg  <= version_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            hdr_bad_reg  <= hdr_bad_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset; every slot is rewritten before an
    // ok result can read it.
    always_ff @(posedge aclk) begin
        rx_lo_reg   <= rx_lo_next;
        rx_hi_reg   <= rx_hi_next;
        m_tdata_reg <= m_tdata_next;
        if (pay_we) begin
            payload_reg[pay_idx] <= s_tdata;
        end
    end

    // A non-ok result carries only its status.
    `CPD_ASSERT(a_fields_zero_unless_ok,
        (m_tvalid_reg && m_tdata_reg[1:0] != cpd_pkg::ST_OK) |-> (m_tdata_reg[89:2] == '0),
        "decoded fields nonzero on a failed packet")
    // A flagged byte rearms the packet state.
    `CPD_ASSERT(a_rearm_after_last,
        (s_accept && s_tlast) |=> (pos_reg == '0 && crc_reg == cpd_pkg::CrcInit && !hdr_bad_reg),
        "packet state not rearmed after final byte")
    // The counter saturates on unflagged trailing bytes.
    `CPD_ASSERT(a_pos_saturates,
        (s_accept && !s_tlast && pos_reg == PosLast) |=> (pos_reg == PosLast),
        "byte counter left saturation")
    // A waiting result blocks the input.
    `CPD_ASSERT_ALWAYS(a_stall_when_full,
        (m_tvalid_reg && !m_tready) |-> !s_tready,
        "input accepted while result register is held")
    // A flagged beat always produces a result.
    `CPD_ASSERT(a_result_follows_last,
        (s_accept && s_tlast) |=> m_tvalid_reg,
        "no result after final byte")

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Run control. The watchdog limit is far above the slowest correct run:
    // about 1900 beats, with random stalls on both sides.
    localparam int unsigned CycleLimit  = 400_000;
    localparam int unsigned DrainCycles = 4;
    localparam int unsigned PhaseBeats  = 360;
    localparam int unsigned NumPhases   = 5;
    localparam int unsigned MaxPrinted  = 40;
    // Neither side idles at random inside this window of cycles.
    localparam int unsigned CalmFrom    = 1500;
    localparam int unsigned CalmTo      = 2500;

    // Indexes that decode to no register; writing them must change nothing.
    localparam logic [cpd_pkg::CfgIdxW-1:0] RegSpareLow  = 2'd2;
    localparam logic [cpd_pkg::CfgIdxW-1:0] RegSpareHigh = 2'd3;

    typedef enum {
        PK_GOOD,
        PK_LONG,
        PK_SHORT,
        PK_BAD_MAGIC,
        PK_BAD_VERSION,
        PK_BAD_CRC,
        PK_NOISE
    } pkt_kind_t;

    // One input beat as it waits in the driver queue.
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } beat_t;

    // One decoded packet as the block should report it.
    typedef struct {
        cpd_pkg::status_t   status;
        logic [7:0]         flags;
        logic [15:0]        seq_no;
        logic [31:0]        stamp;
        logic signed [7:0]  pitch;
        logic signed [7:0]  roll;
        logic signed [7:0]  throttle;
        logic signed [7:0]  yaw;
    } decoded_t;

    // Block ports. Every input has a known value from time zero.
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;  // [7:0] data_byte
    logic                           s_tlast   = 1'b0; // last_byte
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    // [1:0] status, [9:2] flags, [25:10] sequence_res, [57:26] timestamp_ms,
    // [65:58] pitch, [73:66] roll, [81:74] throttle, [89:82] yaw, rest zero
    logic [cpd_pkg::OutDataW-1:0]   m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cpd_pkg::CfgIdxW-1:0]    cfg_index = '0;
    logic [cpd_pkg::CfgDataW-1:0]   cfg_data  = '0;

    // Stimulus and expectation stores.
    beat_t    byte_q[$];     // beats waiting for the driver
    beat_t    held_q[$];     // tail of a packet that straddles a register change
    decoded_t decoded_q[$];  // decoded packets not yet seen on the output

    // Our own copy of the decoder state and its two registers.
    logic [7:0]  magic_reg   = '0;
    logic [7:0]  version_reg = '0;
    logic [3:0]  rx_count    = '0;
    logic [15:0] crc_acc     = cpd_pkg::CrcInit;
    logic        hdr_bad     = 1'b0;
    logic [7:0]  rx_bytes [cpd_pkg::PktLen];

    // Scratch packet used while building stimulus.
    logic [7:0]  pkt_buf [cpd_pkg::PktLen];

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned beats_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned reg_writes    = 0;
    int unsigned queued_beats  = 0;
    int unsigned status_seen [4];

    command_packet_decoder_crc16_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // CRC-16/CCITT-FALSE advanced by one byte, fed one data bit at a time
    // into the feedback of a left-shifting register.
    function automatic logic [15:0] ccitt_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0} ^ (fb ? cpd_pkg::CrcPoly : 16'h0000);
        end
        return r;
    endfunction

    // Random idling on either side, with a chance of about 16 in a hundred, except
    // inside the calm window.
    function automatic logic take_break();
        if (cycle_count >= CalmFrom && cycle_count < CalmTo) begin
            return 1'b0;
        end
        return $urandom_range(99) < 16;
    endfunction

    task automatic flag_mismatch(input string what);
        if (error_count < MaxPrinted) begin
            $display("[%0d] mismatch: %s", cycle_count, what);
        end
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    // Feeds one accepted byte through the decoder state. Bytes beyond the
    // fifteenth leave the state alone, and the position counter therefore
    // stays at fifteen. A flagged byte closes the packet, queues the decoded
    // result and rearms the counter, the CRC and the header flag.
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        decoded_t res;
        logic     ok;
        if (rx_count < cpd_pkg::PktLen) begin
            if (rx_count == 0 && b != magic_reg) begin
                hdr_bad = 1'b1;
            end
            if (rx_count == 1 && b != version_reg) begin
                hdr_bad = 1'b1;
            end
            if (rx_count < cpd_pkg::CrcSpan) begin
                crc_acc = ccitt_step(crc_acc, b);
            end
            rx_bytes[rx_count] = b;
            rx_count = rx_count + 4'd1;
        end
        if (fin) begin
            // Priority: too short, then header, then CRC.
            if (rx_count < cpd_pkg::PktLen) begin
                res.status = cpd_pkg::ST_TOO_SHORT;
            end else if (hdr_bad) begin
                res.status = cpd_pkg::ST_BAD_HDR;
            end else if ({rx_bytes[14], rx_bytes[13]} != crc_acc) begin
                res.status = cpd_pkg::ST_CRC_BAD;
            end else begin
                res.status = cpd_pkg::ST_OK;
            end
            ok           = (res.status == cpd_pkg::ST_OK);
            res.flags    = ok ? rx_bytes[2] : 8'h00;
            res.seq_no   = ok ? {rx_bytes[4], rx_bytes[3]} : 16'h0000;
            res.stamp    = ok ? {rx_bytes[8], rx_bytes[7], rx_bytes[6], rx_bytes[5]} : '0;
            res.pitch    = ok ? rx_bytes[9]  : 8'h00;
            res.roll     = ok ? rx_bytes[10] : 8'h00;
            res.throttle = ok ? rx_bytes[11] : 8'h00;
            res.yaw      = ok ? rx_bytes[12] : 8'h00;
            decoded_q.push_back(res);
            status_seen[res.status]++;
            rx_count = '0;
            crc_acc  = cpd_pkg::CrcInit;
            hdr_bad  = 1'b0;
        end
    endtask

    // Appends the CRC over bytes 0 to 12 of the scratch packet, low byte
    // first; the header bytes are left as they are.
    task automatic seal_packet();
        logic [15:0] c;
        c = cpd_pkg::CrcInit;
        for (int i = 0; i < cpd_pkg::CrcSpan; i++) begin
            c = ccitt_step(c, pkt_buf[i]);
        end
        pkt_buf[13] = c[7:0];
        pkt_buf[14] = c[15:8];
    endtask

    // Sends n beats of the scratch packet, padding past byte 14 with random
    // filler. With split above zero, the beats from that position on are
    // held back until the registers have been rewritten.
    task automatic emit_packet(input int n, input int split);
        beat_t bt;
        for (int i = 0; i < n; i++) begin
            bt.last = (i == n - 1);
            bt.data = (i < cpd_pkg::PktLen) ? pkt_buf[i] : 8'($urandom);
            if (split > 0 && i >= split) begin
                held_q.push_back(bt);
            end else begin
                byte_q.push_back(bt);
            end
            queued_beats++;
        end
    endtask

    task automatic queue_packet(input pkt_kind_t kind, input int split);
        beat_t bt;
        int    n;
        if (kind == PK_NOISE) begin
            // Raw bytes with random flags; the final beat is always flagged so
            // that the following packet starts aligned.
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) begin
                bt.data = 8'($urandom);
                bt.last = (i == n - 1) || ($urandom_range(7) == 0);
                byte_q.push_back(bt);
                queued_beats++;
            end
            return;
        end
        for (int i = cpd_pkg::PayloadFirst; i < cpd_pkg::CrcSpan; i++) begin
            pkt_buf[i] = 8'($urandom);
        end
        pkt_buf[0] = magic_reg;
        pkt_buf[1] = version_reg;
        if (kind == PK_BAD_MAGIC) begin
            pkt_buf[0] ^= 8'($urandom_range(1, 255));
        end
        if (kind == PK_BAD_VERSION) begin
            pkt_buf[1] ^= 8'($urandom_range(1, 255));
        end
        seal_packet();
        if (kind == PK_BAD_CRC) begin
            // A single flipped bit anywhere past the header breaks the check.
            n = $urandom_range(cpd_pkg::PayloadFirst, cpd_pkg::PktLen - 1);
            pkt_buf[n] ^= 8'(1 << $urandom_range(7));
        end
        case (kind)
            PK_LONG:  n = cpd_pkg::PktLen + $urandom_range(1, 20);
            PK_SHORT: n = $urandom_range(1, cpd_pkg::PktLen - 1);
            default:  n = cpd_pkg::PktLen;
        endcase
        emit_packet(n, split);
    endtask

    // Register write over the configuration channel. The model copy is
    // updated at the edge that completes the handshake.
    task automatic write_reg(input logic [cpd_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!(cfg_valid && cfg_ready));
        case (idx)
            cpd_pkg::RegExpectedMagic:   magic_reg   = val;
            cpd_pkg::RegExpectedVersion: version_reg = val;
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Waits until every released beat has been taken and every decoded
    // packet has come out, then lets the block settle.
    task automatic drain();
        do begin
            @(posedge aclk);
        end while (beats_taken + held_q.size() != queued_beats || decoded_q.size() != 0);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // Driver: a beat accepted at this edge goes into the model first; then
    // the next beat is offered unless the random idling holds it back.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_byte(s_tdata, s_tlast);
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (byte_q.size() != 0 && !take_break()) begin
                    {s_tlast, s_tdata} <= byte_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted result beat is checked against the oldest
    // decoded packet, field by field; ready drops at random.
    always @(posedge aclk) begin
        decoded_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    flag_mismatch($sformatf("result beat %0h with nothing expected", m_tdata));
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("status",       m_tdata[1:0],   want.status);
                    compare_field("flags",        m_tdata[9:2],   want.flags);
                    compare_field("sequence",     m_tdata[25:10], want.seq_no);
                    compare_field("timestamp",    m_tdata[57:26], want.stamp);
                    // The signed bytes are compared as raw bit patterns.
                    compare_field("pitch",        m_tdata[65:58], {24'h0, want.pitch});
                    compare_field("roll",         m_tdata[73:66], {24'h0, want.roll});
                    compare_field("throttle",     m_tdata[81:74], {24'h0, want.throttle});
                    compare_field("yaw",          m_tdata[89:82], {24'h0, want.yaw});
                    compare_field("padding",      m_tdata[95:90], 32'h0);
                end
            end
            m_tready <= !take_break();
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("command_packet_decoder_crc16_unit regression: fail");
            $finish;
        end
    end

    initial begin
        logic [7:0]  magic_set   [NumPhases];
        logic [7:0]  version_set [NumPhases];
        int unsigned phase_end;
        int unsigned roll;
        pkt_kind_t   kind;

        for (int i = 0; i < cpd_pkg::PktLen; i++) begin
            rx_bytes[i] = '0;
            pkt_buf[i]  = '0;
        end
        for (int i = 0; i < 4; i++) begin
            status_seen[i] = 0;
        end
        // Register settings per phase: the reset values, all ones, a mixed
        // pattern, a random pair and a mixed pair of extremes.
        magic_set   = '{8'h00, 8'hFF, 8'hA5, 8'h00, 8'h00};
        version_set = '{8'h00, 8'hFF, 8'h3C, 8'h00, 8'hFF};
        magic_set[3]   = 8'($urandom);
        version_set[3] = 8'($urandom);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats under the reset register values. First a good
        // packet with the field extremes, followed by two surplus bytes
        // that the block must ignore, the second of them flagged.
        pkt_buf[0]  = magic_reg;
        pkt_buf[1]  = version_reg;
        pkt_buf[2]  = 8'hFF;
        pkt_buf[3]  = 8'h00;
        pkt_buf[4]  = 8'h80;
        pkt_buf[5]  = 8'hFF;
        pkt_buf[6]  = 8'hFF;
        pkt_buf[7]  = 8'hFF;
        pkt_buf[8]  = 8'hFF;
        pkt_buf[9]  = 8'h80;
        pkt_buf[10] = 8'h7F;
        pkt_buf[11] = 8'hFF;
        pkt_buf[12] = 8'h00;
        seal_packet();
        emit_packet(cpd_pkg::PktLen + 2, 0);
        // A packet of a single flagged byte is the shortest possible one.
        byte_q.push_back('{last: 1'b1, data: 8'hFF});
        queued_beats++;

        for (int p = 0; p < NumPhases; p++) begin
            if (p > 0) begin
                drain();
                write_reg(cpd_pkg::RegExpectedMagic, magic_set[p]);
                write_reg(cpd_pkg::RegExpectedVersion, version_set[p]);
                if (p == 2) begin
                    write_reg(RegSpareLow, 8'hFF);
                    write_reg(RegSpareHigh, 8'h00);
                end
                // Header bytes of the straddling packet sent before the change were
                // judged against the old values; its remainder goes out now.
                while (held_q.size() != 0) begin
                    byte_q.push_back(held_q.pop_front());
                end
            end
            phase_end = queued_beats + PhaseBeats;
            while (queued_beats < phase_end) begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    kind = PK_GOOD;
                end else if (roll < 55) begin
                    kind = PK_LONG;
                end else if (roll < 65) begin
                    kind = PK_SHORT;
                end else if (roll < 72) begin
                    kind = PK_BAD_MAGIC;
                end else if (roll < 79) begin
                    kind = PK_BAD_VERSION;
                end else if (roll < 89) begin
                    kind = PK_BAD_CRC;
                end else begin
                    kind = PK_NOISE;
                end
                queue_packet(kind, 0);
            end
            // Leave a packet open across the register change so that the
            // header bytes are compared with the values they arrived under.
            if (p < NumPhases - 1) begin
                queue_packet(PK_GOOD, 1 + p % 2);
            end
        end

        drain();
        repeat (DrainCycles * 2) @(posedge aclk);

        $display("%0d input beats, %0d results, %0d register writes, %0d cycles",
                 beats_taken, results_seen, reg_writes, cycle_count);
        $display("status mix: ok %0d, too short %0d, bad header %0d, crc mismatch %0d",
                 status_seen[cpd_pkg::ST_OK], status_seen[cpd_pkg::ST_TOO_SHORT],
                 status_seen[cpd_pkg::ST_BAD_HDR], status_seen[cpd_pkg::ST_CRC_BAD]);
        if (error_count == 0) begin
            $display("command_packet_decoder_crc16_unit regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("command_packet_decoder_crc16_unit regression: fail");
        end
        $finish;
    end

endmodule
